// File: rtl/core/whcp_pkg.sv
// Shared types, tags and phase codes for the WAV header parser.
package whcp_pkg;

	// Chunk and container tags, first byte in the top bits
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	// Payload offsets of the captured fmt fields (last byte of each field)
	localparam logic [31:0] FMT_OFF_CHANNELS = 32'd3;
	localparam logic [31:0] FMT_OFF_RATE     = 32'd7;
	localparam logic [31:0] FMT_OFF_BITS     = 32'd15;

	// Last byte index of a 4-byte tag or size field
	localparam logic [31:0] WORD_LAST = 32'd3;

	// Divisor is channels (16 bits) times bytes per sample (13 bits)
	localparam int unsigned DIVISOR_W = 29;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	typedef enum logic [3:0] {
		PH_RIFF  = 4'd0,
		PH_RSIZE = 4'd1,
		PH_WAVE  = 4'd2,
		PH_ID    = 4'd3,
		PH_SIZE  = 4'd4,
		PH_FMT   = 4'd5,
		PH_SKIP  = 4'd6,
		PH_PAD   = 4'd7,
		PH_SINK  = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_TAG = 2'd1,
		ST_MISSING = 2'd2,
		ST_ZERO    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_MUL  = 2'd1,
		BK_DIV  = 2'd2,
		BK_OUT  = 2'd3
	} back_state_t;

	// One parsed file waiting for the frame count
	typedef struct packed {
		status_t     status;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [31:0] data_size;
	} job_t;

	// Queue write side
	typedef struct packed {
		logic push;
		job_t job;
	} job_push_t;

	// Queue read side status
	typedef struct packed {
		logic empty;
		logic full;
		job_t job;
	} job_peek_t;

endpackage

// File: rtl/core/whcp_front.sv
// Byte-wise RIFF/WAVE chunk walker: captures fmt and data fields per file.
module whcp_front
	import whcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] byte_value,
	input  logic       last,
	output job_push_t  wr
);

	phase_t      phase_q, phase_d;
	logic [31:0] cnt_q, cnt_d;
	logic [31:0] len_q, len_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] acc_q, acc_d;
	logic [15:0] ch_q, ch_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] bits_q, bits_d;
	logic [31:0] dsize_q, dsize_d;
	logic        fmt_q, fmt_d;
	logic        data_q, data_d;
	logic        bad_q, bad_d;

	logic [31:0] cnt_inc;
	logic [31:0] tag_nx;
	logic [31:0] acc_nx;
	logic        word_end;
	logic        pay_end;
	logic        hdr_incomplete;

	assign cnt_inc  = cnt_q + 32'd1;
	assign tag_nx   = {tag_q[23:0], byte_value};
	assign acc_nx   = {byte_value, acc_q[31:8]};
	assign word_end = (cnt_q == WORD_LAST);
	assign pay_end  = (cnt_inc == len_q);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_RIFF: begin
				if (word_end) phase_d = (tag_nx == TAG_RIFF) ? PH_RSIZE : PH_SINK;
			end
			PH_RSIZE: begin
				if (word_end) phase_d = PH_WAVE;
			end
			PH_WAVE: begin
				if (word_end) phase_d = (tag_nx == TAG_WAVE) ? PH_ID : PH_SINK;
			end
			PH_ID: begin
				if (word_end) phase_d = PH_SIZE;
			end
			PH_SIZE: begin
				if (word_end) begin
					if (acc_nx == 32'd0) phase_d = PH_ID;
					else if (tag_q == TAG_FMT) phase_d = PH_FMT;
					else phase_d = PH_SKIP;
				end
			end
			PH_FMT, PH_SKIP: begin
				if (pay_end) phase_d = len_q[0] ? PH_PAD : PH_ID;
			end
			PH_PAD: phase_d = PH_ID;
			PH_SINK: phase_d = PH_SINK;
			default: phase_d = PH_SINK;
		endcase
	end

	// Field capture and counters
	always_comb begin
		cnt_d   = cnt_q;
		len_d   = len_q;
		tag_d   = tag_q;
		acc_d   = acc_q;
		ch_d    = ch_q;
		rate_d  = rate_q;
		bits_d  = bits_q;
		dsize_d = dsize_q;
		fmt_d   = fmt_q;
		data_d  = data_q;
		bad_d   = bad_q;
		unique case (phase_q)
			PH_RIFF, PH_WAVE, PH_ID: begin
				tag_d = tag_nx;
				cnt_d = word_end ? 32'd0 : cnt_inc;
				if (word_end && phase_q == PH_RIFF && tag_nx != TAG_RIFF) bad_d = 1'b1;
				if (word_end && phase_q == PH_WAVE && tag_nx != TAG_WAVE) bad_d = 1'b1;
			end
			PH_RSIZE: cnt_d = word_end ? 32'd0 : cnt_inc;
			PH_SIZE: begin
				acc_d = acc_nx;
				cnt_d = word_end ? 32'd0 : cnt_inc;
				if (word_end) begin
					len_d = acc_nx;
					if (tag_q == TAG_FMT) fmt_d = 1'b1;
					if (tag_q == TAG_DATA) begin
						data_d  = 1'b1;
						dsize_d = acc_nx;
					end
				end
			end
			PH_FMT: begin
				acc_d = acc_nx;
				cnt_d = pay_end ? 32'd0 : cnt_inc;
				if (cnt_q == FMT_OFF_CHANNELS) ch_d = acc_nx[31:16];
				if (cnt_q == FMT_OFF_RATE) rate_d = acc_nx;
				if (cnt_q == FMT_OFF_BITS) bits_d = acc_nx[31:16];
			end
			PH_SKIP: cnt_d = pay_end ? 32'd0 : cnt_inc;
			PH_PAD:  cnt_d = 32'd0;
			PH_SINK: cnt_d = cnt_q;
			default: cnt_d = cnt_q;
		endcase
	end

	// Result job built from the state after this byte
	assign hdr_incomplete = (phase_d == PH_RIFF) || (phase_d == PH_RSIZE) ||
		(phase_d == PH_WAVE);

	always_comb begin
		wr.push          = take && last;
		wr.job.channels  = ch_d;
		wr.job.rate      = rate_d;
		wr.job.bits      = bits_d;
		wr.job.data_size = dsize_d;
		priority if (bad_d || phase_d == PH_SINK || hdr_incomplete)
			wr.job.status = ST_BAD_TAG;
		else if (!(fmt_d && data_d))
			wr.job.status = ST_MISSING;
		else
			wr.job.status = ST_OK;
	end

	// State registers; the last byte of a file returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			cnt_q   <= '0;
			len_q   <= '0;
			tag_q   <= '0;
			acc_q   <= '0;
			ch_q    <= '0;
			rate_q  <= '0;
			bits_q  <= '0;
			dsize_q <= '0;
			fmt_q   <= 1'b0;
			data_q  <= 1'b0;
			bad_q   <= 1'b0;
		end else if (take) begin
			if (last) begin
				phase_q <= PH_RIFF;
				cnt_q   <= '0;
				len_q   <= '0;
				tag_q   <= '0;
				acc_q   <= '0;
				ch_q    <= '0;
				rate_q  <= '0;
				bits_q  <= '0;
				dsize_q <= '0;
				fmt_q   <= 1'b0;
				data_q  <= 1'b0;
				bad_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				len_q   <= len_d;
				tag_q   <= tag_d;
				acc_q   <= acc_d;
				ch_q    <= ch_d;
				rate_q  <= rate_d;
				bits_q  <= bits_d;
				dsize_q <= dsize_d;
				fmt_q   <= fmt_d;
				data_q  <= data_d;
				bad_q   <= bad_d;
			end
		end
	end

endmodule

// File: rtl/core/whcp_fifo.sv
// Short job queue between the parser front and the divider back.
module whcp_fifo
	import whcp_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF // at least 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  job_push_t wr,
	input  logic      pop,
	output job_peek_t rd
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign rd.empty = (count_q == '0);
	assign rd.full  = (count_q == CNT_FULL);
	assign rd.job   = slot_q[rd_ptr_q];
	assign do_push  = wr.push && !rd.full;
	assign do_pop   = pop && !rd.empty;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= wr.job;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/whcp_back.sv
// Result stage: frame size multiply, bit-serial frame count division, output register.
module whcp_back
	import whcp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  job_peek_t    rd,
	output logic         pop,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata
);

	back_state_t          state_q, state_d;
	status_t              status_q;
	logic [15:0]          ch_q;
	logic [31:0]          rate_q;
	logic [15:0]          bits_q;
	logic [31:0]          size_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [31:0]          quot_q;
	logic [4:0]           step_q;

	logic [DIVISOR_W-1:0] prod;
	logic                 zero_div;
	logic                 run_div;
	logic [DIVISOR_W:0]   rem_sh;
	logic [DIVISOR_W:0]   rem_sub;
	logic                 rem_ge;

	assign prod     = {13'd0, ch_q} * {16'd0, bits_q[15:3]};
	assign zero_div = (ch_q == 16'd0) || (bits_q[15:3] == 13'd0);
	assign run_div  = (status_q == ST_OK) && !zero_div;
	assign rem_sh   = {rem_q, quot_q[31]};
	assign rem_sub  = rem_sh - {1'b0, div_q};
	assign rem_ge   = (rem_sh >= {1'b0, div_q});

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (!rd.empty) state_d = BK_MUL;
			BK_MUL:  state_d = run_div ? BK_DIV : BK_OUT;
			BK_DIV:  if (step_q == 5'd31) state_d = BK_OUT;
			BK_OUT:  if (m_axis_tready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		pop           = (state_q == BK_IDLE) && !rd.empty;
		m_axis_tvalid = (state_q == BK_OUT);
	end

	// tdata fields from bit 0: status, channel_count, sample_rate,
	// bits_per_sample, payload_bytes, frame_count, zero fill
	assign m_axis_tdata = {6'd0, quot_q, size_q, bits_q, rate_q, ch_q, status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (!rd.empty) begin
					status_q <= rd.job.status;
					ch_q     <= rd.job.channels;
					rate_q   <= rd.job.rate;
					bits_q   <= rd.job.bits;
					size_q   <= rd.job.data_size;
				end
			end
			BK_MUL: begin
				div_q  <= prod;
				rem_q  <= '0;
				step_q <= '0;
				quot_q <= run_div ? size_q : 32'd0;
				if (status_q == ST_OK && zero_div) status_q <= ST_ZERO;
			end
			BK_DIV: begin
				rem_q  <= rem_ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
				quot_q <= {quot_q[30:0], rem_ge};
				step_q <= step_q + 5'd1;
			end
			BK_OUT: ;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// During division the partial remainder stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (rem_q < div_q))
		else $error("remainder not below divisor");
	// An error result never carries a frame count
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status_q != ST_OK) |-> (quot_q == 32'd0))
		else $error("frame count on error status");
	// Division only runs with a nonzero divisor and good status
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (div_q != '0 && status_q == ST_OK))
		else $error("division started with zero divisor");
	// A job is taken only when the back stage is free
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == BK_MUL))
		else $error("job popped but not started");
`endif

endmodule

// File: rtl/core/wav_header_chunk_parser_unit.sv
// Top level of the RIFF/WAVE header parser: front walker, job queue, divider back.
//
// Takes a WAV file one byte per item (tlast on the final byte) and returns
// one result item per file: status, channel count, sample rate, bits per
// sample, data chunk size and frame count. Bytes are accepted at one per
// cycle; the input stalls only while the job queue is full. Each file's
// result goes through the job take, the frame-size multiply and the
// bit-serial restoring divider, then the output register, which holds
// until taken. Error results skip the divider. The queue of QUEUE_DEPTH
// jobs (at least 2) lets the parser run ahead into the next file while
// a result is being computed or waits at the output.
module wav_header_chunk_parser_unit
	import whcp_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // byte_value
	input  logic         s_axis_tlast,  // last
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata   // status, channel_count, sample_rate,
	                                    // bits_per_sample, payload_bytes,
	                                    // frame_count, zero fill
);

	job_push_t wr;
	job_peek_t rd;
	logic      pop;
	logic      take;

	assign s_axis_tready = !rd.full;
	assign take          = s_axis_tvalid && s_axis_tready;

	whcp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.byte_value (s_axis_tdata),
		.last       (s_axis_tlast),
		.wr         (wr)
	);

	whcp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.rd     (rd)
	);

	whcp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd            (rd),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
